[rtl/rsws_pkg.sv]
// ----------------------------------------------------------------------------
// rsws_pkg
// Shared constants and types for the random sample without replacement block.
// ----------------------------------------------------------------------------
package rsws_pkg;

  // store geometry
  localparam int MAX_CELLS = 1024;
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int CNT_W     = CELL_W + 1;
  localparam int TAG_W     = 8;
  localparam int ENTRY_W   = TAG_W + CELL_W;

  // field widths
  localparam int INDEX_W   = 10;
  localparam int CFG_W     = 11;
  localparam int SEED_W    = 64;
  localparam int CFG_ADDR_W = 2;

  // generator constants
  localparam logic [63:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] PCG_INC  = 64'd1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CELL_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRAW_LIMIT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEED       = 2'd2;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TAG_W-1:0]  tag_t;

endpackage

[rtl/rsws_if.sv]
// ----------------------------------------------------------------------------
// rsws interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsws_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rsws_rsp_if;
  import rsws_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic               last;
  logic               error;
  modport source (output valid, output index, output last, output error, input ready);
  modport sink   (input valid, input index, input last, input error, output ready);
endinterface

interface rsws_cfg_if;
  import rsws_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [SEED_W-1:0]     data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[rtl/random_sample_without_replacement.sv]
// ----------------------------------------------------------------------------
// random_sample_without_replacement
// Partial Fisher-Yates shuffle over a tagged permutation RAM, PCG32 source.
// ----------------------------------------------------------------------------
// Each request returns one result. A draw runs, from the accepted request to
// its result, a serial remainder for the rejection threshold, a generator
// step, another serial remainder for the pick, then two RAM reads and two
// writes. Each rejected output adds a generator step. Error results skip
// these steps. After reset, and on every 255th restart when the entry tag
// wraps, a clearing pass sweeps the permutation RAM before further requests
// are taken. Configuration writes are always accepted.
module random_sample_without_replacement (
  input logic        clk,
  input logic        rst,
  rsws_req_if.sink   req,
  rsws_rsp_if.source rsp,
  rsws_cfg_if.sink   cfg
);
  import rsws_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_THR   = 4'd3;
  localparam logic [3:0] S_GEN   = 4'd4;
  localparam logic [3:0] S_GWAIT = 4'd5;
  localparam logic [3:0] S_RMOD  = 4'd6;
  localparam logic [3:0] S_RDJ   = 4'd7;
  localparam logic [3:0] S_RDK   = 4'd8;
  localparam logic [3:0] S_WR2   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]        state;
  logic [CFG_W-1:0]  num_cells;
  logic [CFG_W-1:0]  draw_limit;
  logic [SEED_W-1:0] seed;
  cnt_t              count;
  tag_t              ep;
  cell_t             clr_addr;
  logic              clr_chk;
  cnt_t              thr;
  logic [31:0]       r;
  cell_t             jpos;
  cell_t             at_j;
  cnt_t              bound;
  cnt_t              cells;
  cnt_t              jsum;
  cell_t             rd_val;
  logic              res_err;
  logic              res_last;
  cell_t             res_index;

  logic              ov;
  logic [INDEX_W-1:0] o_index;
  logic              o_last;
  logic              o_error;

  logic              pcg_load;
  logic              pcg_step;
  logic              pcg_done;
  logic [31:0]       rnd;
  logic              mod_start;
  logic [31:0]       mod_dd;
  logic              mod_done;
  cnt_t              mod_rem;

  logic              ram_we;
  cell_t             ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  cell_t             ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic              accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign pcg_load  = accept && req.restart;

  // effective cell count and remaining range
  assign cells = (num_cells > CFG_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(num_cells);
  assign bound = cells - count;
  assign jsum  = count + mod_rem;

  // entry read: untagged entries hold their own position
  always_comb begin
    if (ram_rdata[ENTRY_W-1 -: TAG_W] == ep) begin
      rd_val = ram_rdata[CELL_W-1:0];
    end else if (state == S_RDJ) begin
      rd_val = jpos;
    end else begin
      rd_val = count[CELL_W-1:0];
    end
  end

  // remainder unit operand
  assign mod_start = (state == S_CHECK && !(count >= CNT_W'(draw_limit) || count >= cells))
                  || (state == S_GWAIT && pcg_done && r >= 32'(thr));
  assign mod_dd    = (state == S_CHECK) ? (32'd0 - 32'(bound)) : r;
  assign pcg_step  = (state == S_GEN);

  // ram port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: ram_we = 1'b1;
      S_RDK: begin
        ram_we    = 1'b1;
        ram_waddr = jpos;
        ram_wdata = {ep, rd_val};
      end
      S_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = count[CELL_W-1:0];
        ram_wdata = {ep, at_j};
      end
      default: ;
    endcase
    ram_raddr = (state == S_RMOD) ? jsum[CELL_W-1:0] : count[CELL_W-1:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cells  <= CFG_W'(MAX_CELLS);
      draw_limit <= '0;
      seed       <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.addr)
        CFG_CELL_COUNT: num_cells  <= cfg.data[CFG_W-1:0];
        CFG_DRAW_LIMIT: draw_limit <= cfg.data[CFG_W-1:0];
        CFG_SEED:       seed       <= cfg.data;
        default: ;
      endcase
    end
  end

  // draw sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      clr_chk  <= 1'b0;
      ep       <= tag_t'(1);
      count    <= '0;
      res_err  <= 1'b0;
      res_last <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.restart) begin
              count <= '0;
              if (ep == '1) begin
                state    <= S_CLEAR;
                clr_addr <= '0;
                clr_chk  <= 1'b1;
              end else begin
                ep    <= ep + tag_t'(1);
                state <= S_CHECK;
              end
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + cell_t'(1);
          if (clr_addr == '1) begin
            ep      <= tag_t'(1);
            clr_chk <= 1'b0;
            state   <= clr_chk ? S_CHECK : S_IDLE;
          end
        end
        S_CHECK: begin
          if (count >= CNT_W'(draw_limit) || count >= cells) begin
            res_err   <= 1'b1;
            res_last  <= 1'b0;
            res_index <= '0;
            state     <= S_OUT;
          end else begin
            state <= S_THR;
          end
        end
        S_THR: begin
          if (mod_done) begin
            thr   <= mod_rem;
            state <= S_GEN;
          end
        end
        S_GEN: begin
          r     <= rnd;
          state <= S_GWAIT;
        end
        S_GWAIT: begin
          if (pcg_done) begin
            state <= (r >= 32'(thr)) ? S_RMOD : S_GEN;
          end
        end
        S_RMOD: begin
          if (mod_done) begin
            jpos  <= jsum[CELL_W-1:0];
            state <= S_RDJ;
          end
        end
        S_RDJ: begin
          at_j  <= rd_val;
          state <= S_RDK;
        end
        S_RDK: begin
          state <= S_WR2;
        end
        S_WR2: begin
          count     <= count + cnt_t'(1);
          res_err   <= 1'b0;
          res_last  <= (count + cnt_t'(1)) == CNT_W'(draw_limit);
          res_index <= at_j;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!ov || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == S_OUT && (!ov || rsp.ready)) begin
      ov      <= 1'b1;
      o_index <= INDEX_W'(res_index);
      o_last  <= res_last;
      o_error <= res_err;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  assign rsp.valid = ov;
  assign rsp.index = o_index;
  assign rsp.last  = o_last;
  assign rsp.error = o_error;

  rsws_pcg u_pcg (
    .clk  (clk),
    .rst  (rst),
    .load (pcg_load),
    .seed (seed),
    .step (pcg_step),
    .done (pcg_done),
    .rnd  (rnd)
  );

  rsws_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dd),
    .divisor  (bound),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  rsws_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[rtl/rsws_ram.sv]
// ----------------------------------------------------------------------------
// rsws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rsws_pcg.sv]
// ----------------------------------------------------------------------------
// rsws_pcg
// PCG32 generator state with a multi-cycle LCG step on one 32x32 multiplier.
// ----------------------------------------------------------------------------
module rsws_pcg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [rsws_pkg::SEED_W-1:0] seed,
  input  logic                      step,
  output logic                      done,
  output logic [31:0]               rnd
);
  import rsws_pkg::*;

  logic [63:0] st;
  logic [63:0] prod;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [2:0]  phase;
  logic        busy;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [31:0] mixed;
  logic [4:0]  rot;

  // xsh-rr output from the current state
  always_comb begin
    mixed = 32'(((st >> 18) ^ st) >> 27);
    rot   = st[63:59];
    rnd   = (mixed >> rot) | (mixed << ((5'd0 - rot) & 5'd31));
  end

  // multiplier operand select per phase
  always_comb begin
    unique case (phase)
      3'd0:    begin ma = st[31:0];  mb = PCG_MULT[31:0];  end
      3'd1:    begin ma = st[31:0];  mb = PCG_MULT[63:32]; end
      default: begin ma = st[63:32]; mb = PCG_MULT[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // step sequencer: low product, two cross products, then increment
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      busy  <= 1'b0;
      phase <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        st <= seed;
      end
      if (!busy) begin
        if (step) begin
          busy  <= 1'b1;
          phase <= 3'd1;
        end
      end else begin
        unique case (phase)
          3'd1: begin
            lo    <= prod[31:0];
            hi    <= prod[63:32];
            phase <= 3'd2;
          end
          3'd2: begin
            hi    <= hi + prod[31:0];
            phase <= 3'd3;
          end
          3'd3: begin
            hi    <= hi + prod[31:0];
            phase <= 3'd4;
          end
          default: begin
            st    <= {hi, lo} + PCG_INC;
            busy  <= 1'b0;
            phase <= 3'd0;
            done  <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

[rtl/rsws_mod.sv]
// ----------------------------------------------------------------------------
// rsws_mod
// Bit-serial 32-bit remainder by an 11-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rsws_mod (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              dividend,
  input  logic [rsws_pkg::CNT_W-1:0] divisor,
  output logic                     done,
  output logic [rsws_pkg::CNT_W-1:0] rem
);
  import rsws_pkg::*;

  logic [31:0]    dd;
  logic [CNT_W-1:0] dv;
  logic [5:0]     cnt;
  logic           busy;
  logic [CNT_W:0] trial;

  assign trial = {rem, dd[31]};

  // restoring remainder loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        dd   <= dividend;
        dv   <= divisor;
        rem  <= '0;
        cnt  <= 6'd32;
      end else if (busy) begin
        if (trial >= {1'b0, dv}) begin
          rem <= CNT_W'(trial - {1'b0, dv});
        end else begin
          rem <= CNT_W'(trial);
        end
        dd  <= dd << 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
